// File: hdl/lowest_free_slot_allocator_unit_macros.svh
// Assertion macros for the slot allocator checker.
`ifndef LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LFSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// Next-cycle implication, disabled in reset.
`define LFSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

// File: hdl/lfsa_pkg.sv
`default_nettype none

package lfsa_pkg;

   localparam int FIELD_ID_W = 9;
   localparam int STATUS_W   = 2;
   localparam int CELL_BITS  = 32;
   localparam int CELL_OFF_W = 5;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic                  mode;
      logic [FIELD_ID_W-1:0] slot_to_free;
   } req_type;

   typedef struct packed {
      logic [FIELD_ID_W-1:0] granted_id;
      logic [STATUS_W-1:0]   status;
      logic [FIELD_ID_W-1:0] high_water;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic mode;
      logic act;
      logic search;
      logic found;
      logic hit;
   } tok_ctl_type;

   typedef struct packed {
      logic                  found;
      logic [CELL_OFF_W-1:0] idx;
   } zfind_type;

   function automatic zfind_type find_zero(input logic [CELL_BITS-1:0] v);
      zfind_type r;
      r.found = 1'b0;
      r.idx   = '0;
      for (int i = CELL_BITS - 1; i >= 0; i--) begin
         if (!v[i]) begin
            r.found = 1'b1;
            r.idx   = CELL_OFF_W'(i);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/lfsa_cell.sv
`default_nettype none

module lfsa_cell #(
   parameter int SLOT_BASE  = 0,
   parameter int SLOT_COUNT = 32,
   parameter int ID_W       = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lfsa_pkg::tok_ctl_type in_ctl,
   input  wire logic [ID_W-1:0]      in_id,
   input  wire logic [ID_W-1:0]      in_fidx,
   output lfsa_pkg::tok_ctl_type     out_ctl,
   output logic [ID_W-1:0]           out_id,
   output logic [ID_W-1:0]           out_fidx
);

   localparam int CB = lfsa_pkg::CELL_BITS;
   localparam logic [ID_W-1:0] BASE      = ID_W'(SLOT_BASE);
   localparam logic [ID_W-1:0] LIMIT     = ID_W'(SLOT_BASE + SLOT_COUNT);
   localparam logic [ID_W-1:0] FIDX_BASE = ID_W'(SLOT_BASE + 1);
   localparam logic [CB:0]     TOP_BIT   = (CB + 1)'(1) << SLOT_COUNT;
   localparam logic [CB-1:0]   LIVE      = CB'(TOP_BIT - (CB + 1)'(1));

   logic [CB-1:0]                  bits_ff;
   logic [CB-1:0]                  bits_in;
   lfsa_pkg::tok_ctl_type          ctl_ff;
   lfsa_pkg::tok_ctl_type          ctl_in;
   logic [ID_W-1:0]                id_ff;
   logic [ID_W-1:0]                fidx_ff;
   logic [ID_W-1:0]                fidx_in;
   logic [ID_W-1:0]                slot0;
   logic                           in_cell;
   logic [lfsa_pkg::CELL_OFF_W-1:0] off;
   logic [CB-1:0]                  sel;
   logic                           hit;
   lfsa_pkg::zfind_type            zf;

   always_comb begin
      slot0   = in_id - ID_W'(1);
      in_cell = in_ctl.valid && in_ctl.act && (slot0 >= BASE) && (slot0 < LIMIT);
      off     = lfsa_pkg::CELL_OFF_W'(slot0 - BASE);
      sel     = CB'(1) << off;
      hit     = |(bits_ff & sel);
      bits_in = bits_ff;
      if (in_cell) begin
         if (in_ctl.mode == lfsa_pkg::MODE_ALLOC) begin
            bits_in = bits_ff | sel;
         end else begin
            bits_in = bits_ff & ~sel;
         end
      end
      // padding beyond the pool reads as used
      zf      = lfsa_pkg::find_zero(bits_in | ~LIVE);
      ctl_in  = in_ctl;
      fidx_in = in_fidx;
      if (in_cell && (in_ctl.mode == lfsa_pkg::MODE_FREE)) begin
         ctl_in.hit = hit;
      end
      if (in_ctl.search && !in_ctl.found && zf.found) begin
         ctl_in.found = 1'b1;
         fidx_in      = FIDX_BASE + ID_W'(zf.idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff      <= '0;
         ctl_ff.valid <= 1'b0;
      end else begin
         bits_ff      <= bits_in;
         ctl_ff.valid <= in_ctl.valid;
      end
      ctl_ff.mode   <= ctl_in.mode;
      ctl_ff.act    <= ctl_in.act;
      ctl_ff.search <= ctl_in.search;
      ctl_ff.found  <= ctl_in.found;
      ctl_ff.hit    <= ctl_in.hit;
      id_ff         <= in_id;
      fidx_ff       <= fidx_in;
   end

   assign out_ctl  = ctl_ff;
   assign out_id   = id_ff;
   assign out_fidx = fidx_ff;

endmodule

`default_nettype wire

// File: hdl/lowest_free_slot_allocator_unit.sv
// Channel   Ports                          Transfer when
// request   req_valid req_stall req_data   req_valid and not req_stall
// response  rsp_valid rsp_stall rsp_data   rsp_valid and not rsp_stall
//
// Each request is registered at the entry, then in one register per cell of
// 32 slots as it walks the cell chain, then in the tail register, and lands
// in the response register.
// Synchronous reset clears every occupancy bit at once; no sweep follows.
// req_stall is high while a request is in flight; a stalled response holds
// the finished request at the chain tail until it can move out.
`default_nettype none

module lowest_free_slot_allocator_unit #(
   parameter int SLOTS = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire lfsa_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lfsa_pkg::rsp_type     rsp_data
);

   localparam int CB    = lfsa_pkg::CELL_BITS;
   localparam int NCELL = (SLOTS + CB - 1) / CB;
   localparam int ID_W  = $clog2(SLOTS + 2);
   localparam logic [ID_W-1:0] NF_NONE = ID_W'(SLOTS + 1);

   lfsa_pkg::tok_ctl_type ctl_chain  [0:NCELL];
   logic [ID_W-1:0]       id_chain   [0:NCELL];
   logic [ID_W-1:0]       fidx_chain [0:NCELL];

   lfsa_pkg::tok_ctl_type entry_ctl_ff, entry_ctl_in;
   logic [ID_W-1:0]       entry_id_ff, entry_id_in;
   lfsa_pkg::tok_ctl_type tail_ctl_ff, tail_ctl_in;
   logic [ID_W-1:0]       tail_id_ff, tail_id_in;
   logic [ID_W-1:0]       tail_fidx_ff, tail_fidx_in;
   logic [ID_W-1:0]       hw_ff, hw_in;
   logic [ID_W-1:0]       nf_ff, nf_in;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   lfsa_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  accept;
   logic                  done;

   assign ctl_chain[0]  = entry_ctl_ff;
   assign id_chain[0]   = entry_id_ff;
   assign fidx_chain[0] = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      lfsa_cell #(
         .SLOT_BASE  (k * CB),
         .SLOT_COUNT ((k == NCELL - 1) ? (SLOTS - (NCELL - 1) * CB) : CB),
         .ID_W       (ID_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_ctl   (ctl_chain[k]),
         .in_id    (id_chain[k]),
         .in_fidx  (fidx_chain[k]),
         .out_ctl  (ctl_chain[k+1]),
         .out_id   (id_chain[k+1]),
         .out_fidx (fidx_chain[k+1])
      );
   end

   assign accept = req_valid && !busy_ff;
   assign done   = tail_ctl_ff.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      entry_ctl_in        = '0;
      entry_id_in         = entry_id_ff;
      if (accept) begin
         entry_ctl_in.valid = 1'b1;
         entry_ctl_in.mode  = req_data.mode;
         if (req_data.mode == lfsa_pkg::MODE_ALLOC) begin
            entry_id_in         = nf_ff;
            entry_ctl_in.act    = (nf_ff != NF_NONE);
            entry_ctl_in.search = (nf_ff != NF_NONE) && (nf_ff != hw_ff + ID_W'(1));
         end else begin
            entry_id_in      = ID_W'(req_data.slot_to_free);
            entry_ctl_in.act = (req_data.slot_to_free != '0) &&
                               (32'(req_data.slot_to_free) <= 32'(hw_ff));
         end
      end

      tail_ctl_in  = tail_ctl_ff;
      tail_id_in   = tail_id_ff;
      tail_fidx_in = tail_fidx_ff;
      if (ctl_chain[NCELL].valid) begin
         tail_ctl_in  = ctl_chain[NCELL];
         tail_id_in   = id_chain[NCELL];
         tail_fidx_in = fidx_chain[NCELL];
      end else if (done) begin
         tail_ctl_in.valid = 1'b0;
      end

      hw_in  = hw_ff;
      nf_in  = nf_ff;
      rsp_in = rsp_ff;
      if (done) begin
         rsp_in.granted_id = '0;
         rsp_in.status     = lfsa_pkg::STATUS_OK;
         if (tail_ctl_ff.mode == lfsa_pkg::MODE_ALLOC) begin
            if (!tail_ctl_ff.act) begin
               rsp_in.status = lfsa_pkg::STATUS_FULL;
            end else begin
               rsp_in.granted_id = lfsa_pkg::FIELD_ID_W'(tail_id_ff);
               if (tail_ctl_ff.search) begin
                  nf_in = tail_ctl_ff.found ? tail_fidx_ff : NF_NONE;
               end else begin
                  hw_in = hw_ff + ID_W'(1);
                  nf_in = nf_ff + ID_W'(1);
               end
            end
         end else begin
            if (tail_ctl_ff.act && tail_ctl_ff.hit) begin
               if (tail_id_ff < nf_ff) begin
                  nf_in = tail_id_ff;
               end
            end else begin
               rsp_in.status = lfsa_pkg::STATUS_BAD_FREE;
            end
         end
         rsp_in.high_water = lfsa_pkg::FIELD_ID_W'(hw_in);
      end

      rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
      busy_in      = accept || (busy_ff && !done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ctl_ff.valid <= 1'b0;
         tail_ctl_ff.valid  <= 1'b0;
         hw_ff              <= '0;
         nf_ff              <= ID_W'(1);
         busy_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         entry_ctl_ff.valid <= entry_ctl_in.valid;
         tail_ctl_ff.valid  <= tail_ctl_in.valid;
         hw_ff              <= hw_in;
         nf_ff              <= nf_in;
         busy_ff            <= busy_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      entry_ctl_ff.mode   <= entry_ctl_in.mode;
      entry_ctl_ff.act    <= entry_ctl_in.act;
      entry_ctl_ff.search <= entry_ctl_in.search;
      entry_ctl_ff.found  <= entry_ctl_in.found;
      entry_ctl_ff.hit    <= entry_ctl_in.hit;
      entry_id_ff         <= entry_id_in;
      tail_ctl_ff.mode    <= tail_ctl_in.mode;
      tail_ctl_ff.act     <= tail_ctl_in.act;
      tail_ctl_ff.search  <= tail_ctl_in.search;
      tail_ctl_ff.found   <= tail_ctl_in.found;
      tail_ctl_ff.hit     <= tail_ctl_in.hit;
      tail_id_ff          <= tail_id_in;
      tail_fidx_ff        <= tail_fidx_in;
      rsp_ff              <= rsp_in;
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/lfsa_checker.sv
`default_nettype none
`include "lowest_free_slot_allocator_unit_macros.svh"

module lfsa_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire lfsa_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire lfsa_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic rsp_err;
   logic rsp_grant;
   logic grant_le_mark;

   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_err       = rsp_valid && (rsp_data.status != lfsa_pkg::STATUS_OK);
   assign rsp_grant     = rsp_valid && (rsp_data.granted_id != '0);
   assign grant_le_mark = rsp_data.granted_id <= rsp_data.high_water;

   // hold a stalled response
   `LFSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // stall after every accepted request
   `LFSA_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

   `LFSA_ASSERT_NOW(a_err_no_grant, clock, reset, rsp_err, rsp_data.granted_id == '0)

   `LFSA_ASSERT_NOW(a_grant_in_mark, clock, reset, rsp_grant, grant_le_mark)

endmodule

bind lowest_free_slot_allocator_unit lfsa_checker u_lfsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
